// ===== src/ypbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ypbd_pkg;

  localparam int unsigned MaxClasses   = 256;
  localparam int unsigned MaxKeypoints = 32;
  localparam int unsigned BoxFields    = 4;
  localparam int unsigned CoefCount    = 6;

  localparam int unsigned DataW    = 32;
  localparam int unsigned ClassW   = 8;
  localparam int unsigned KptIdxW  = 5;
  localparam int unsigned PosW     = 9;
  localparam int unsigned NcW      = 9;
  localparam int unsigned NkW      = 6;
  localparam int unsigned ThrW     = 17;
  localparam int unsigned ObjW     = 11;
  localparam int unsigned CoefIdxW = 3;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned ProdW    = 48;
  localparam int unsigned SumW     = 50;

  // tdata: coef_index, value, then zero pad to whole bytes
  localparam int unsigned InTdataW  = 40;
  // tdata: coord_a, coord_b, box_width, box_height, score, label,
  // keypoint_index, then zero pad to whole bytes
  localparam int unsigned OutPadW   = 3;
  localparam int unsigned OutTdataW = 176;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_PRED = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_BOX = 1'b0,
    KIND_KPT = 1'b1
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_CLASS_COUNT    = 2'd0,
    REG_NUM_KEYPOINTS  = 2'd1,
    REG_CONF_THRESHOLD = 2'd2,
    REG_MAX_OBJECTS    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KP_X    = 2'd0,
    KP_Y    = 2'd1,
    KP_CONF = 2'd2
  } kp_phase_e;

  typedef struct packed {
    kind_e               kind;
    logic [DataW-1:0]    score;
    logic [ClassW-1:0]   label;
    logic [KptIdxW-1:0]  kpt_idx;
    logic                last;
  } ypbd_meta_t;

  typedef struct packed {
    ypbd_meta_t                      meta;
    logic [DataW-1:0]                x0;
    logic [DataW-1:0]                y0;
    logic [DataW-1:0]                x1;
    logic [DataW-1:0]                y1;
    logic [CoefCount-1:0][DataW-1:0] coef;
  } ypbd_req_t;

  typedef struct packed {
    kind_e              kind;
    logic [DataW-1:0]   coord_a;
    logic [DataW-1:0]   coord_b;
    logic [DataW-1:0]   box_width;
    logic [DataW-1:0]   box_height;
    logic [DataW-1:0]   score;
    logic [ClassW-1:0]  label;
    logic [KptIdxW-1:0] keypoint_index;
    logic               last;
  } ypbd_res_t;

  // clamp a signed 33-bit value to the signed 32-bit range
  function automatic logic [DataW-1:0] sat_s33(input logic [DataW:0] v);
    logic [DataW-1:0] r;
    if (v[DataW] == v[DataW-1]) begin
      r = v[DataW-1:0];
    end else if (v[DataW]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

  // clamp a signed SumW-bit value to the signed 32-bit range
  function automatic logic [DataW-1:0] sat_sum(input logic [SumW-1:0] v);
    logic [SumW-DataW:0] hi;
    logic [DataW-1:0]    r;
    hi = v[SumW-1:DataW-1];
    if ((&hi) || (~|hi)) begin
      r = v[DataW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/yolo_pose_box_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming decoder for the output tensor of a pose detector.
// Input stream (s_axis): tuser = cmd. cmd load writes affine coefficient
// coef_index (Q16.16) and restarts the frame; cmd predict carries one tensor
// value. Each anchor row is cx, cy, w, h, one score per class, then
// num_keypoints triples (x, y, conf).
// Output stream (m_axis): tuser = kind (box or keypoint), tlast marks the
// last result of one object. A kept anchor gives a box on its last class score
// and one keypoint result on each keypoint confidence.
// Config channel (cfg_*): always ready; write only while the block is idle.
// Throughput: one input transfer per cycle while s_axis tready is high. A
// result passes the registers of the projection pipeline in order (operand
// register, bank of eight 32x32 multipliers, sum and saturate, center and
// size) before it shows on m_axis. Values that give no result leave the
// pipeline untouched. Reset clears the configuration to its defaults, the
// coefficients and all frame state. When m_axis stalls, the pipeline fills
// up and s_axis tready drops only once every stage holds a result.
module yolo_pose_box_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // coef_index[2:0], value[34:3], zero pad
  input  logic [ypbd_pkg::InTdataW-1:0]     s_axis_tdata,
  // cmd
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // coord_a[31:0], coord_b[63:32], box_width[95:64], box_height[127:96],
  // score[159:128], label[167:160], keypoint_index[172:168], zero pad
  output logic [ypbd_pkg::OutTdataW-1:0]    m_axis_tdata,
  // kind
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ypbd_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [ypbd_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  import ypbd_pkg::*;

  // configuration
  logic [NcW-1:0]  cls_count_q;
  logic [NkW-1:0]  num_kpts_q;
  logic [ThrW-1:0] conf_thr_q;
  logic [ObjW-1:0] max_obj_q;

  // frame state
  logic [CoefCount-1:0][DataW-1:0] coef_q, coef_d;
  logic [BoxFields-1:0][DataW-1:0] box_q, box_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [DataW-1:0]   best_q, best_d;
  logic [ClassW-1:0]  label_q, label_d;
  logic [ObjW-1:0]    kept_q, kept_d;
  logic               anchor_q, anchor_d;
  logic               full_q, full_d;
  logic [DataW-1:0]   kpx_q, kpx_d, kpy_q, kpy_d;
  logic [KptIdxW-1:0] kpc_q, kpc_d;

  // input fields
  logic                in_xfer;
  cmd_e                in_cmd;
  logic [CoefIdxW-1:0] in_idx;
  logic [DataW-1:0]    in_value;

  // row geometry
  logic [NcW-1:0]    nc_eff;
  logic [NkW-1:0]    nk_eff;
  logic [PosW-1:0]   cls_end, row_len, pos_inc, kp_k;
  logic [ClassW-1:0] cls_idx;
  logic              cls_first, cls_last;
  kp_phase_e         kp_phase;

  logic [DataW-1:0]  best_new;
  logic [ClassW-1:0] label_new;
  logic              thr_pass, keep;
  logic [ObjW-1:0]   kept_inc;

  logic [DataW:0]    cx_x, cy_x, hw_x, hh_x;

  logic       emit;
  ypbd_req_t  req;
  logic       proj_ready;
  logic       res_valid;
  ypbd_res_t  res;

  // value mod 3 by folding base-4 digits (4 = 1 mod 3)
  function automatic logic [1:0] mod3(input logic [PosW-1:0] k);
    logic [3:0] s;
    logic [2:0] u;
    logic [2:0] w;
    logic [1:0] r;
    s = 4'(k[1:0]) + 4'(k[3:2]) + 4'(k[5:4]) + 4'(k[7:6]) + 4'(k[8]);
    u = 3'(s[1:0]) + 3'(s[3:2]);
    w = 3'(u[1:0]) + 3'(u[2]);
    if (w >= 3'd3) begin
      r = 2'(w - 3'd3);
    end else begin
      r = w[1:0];
    end
    return r;
  endfunction

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_cmd   = cmd_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[CoefIdxW-1:0];
  assign in_value = s_axis_tdata[CoefIdxW+DataW-1:CoefIdxW];

  always_comb begin
    if (cls_count_q == '0) begin
      nc_eff = NcW'(1);
    end else if (cls_count_q > NcW'(MaxClasses)) begin
      nc_eff = NcW'(MaxClasses);
    end else begin
      nc_eff = cls_count_q;
    end
    if (num_kpts_q > NkW'(MaxKeypoints)) begin
      nk_eff = NkW'(MaxKeypoints);
    end else begin
      nk_eff = num_kpts_q;
    end
  end

  assign cls_end   = PosW'(BoxFields) + PosW'(nc_eff);
  assign row_len   = cls_end + PosW'({nk_eff, 1'b0}) + PosW'(nk_eff);
  assign pos_inc   = pos_q + PosW'(1);
  assign cls_idx   = ClassW'(pos_q - PosW'(BoxFields));
  assign cls_first = (pos_q == PosW'(BoxFields));
  assign cls_last  = (pos_inc == cls_end);
  assign kp_k      = pos_q - cls_end;
  assign kp_phase  = kp_phase_e'(mod3(kp_k));

  // running argmax, first maximum wins
  always_comb begin
    if (cls_first || ($signed(in_value) > $signed(best_q))) begin
      best_new  = in_value;
      label_new = cls_idx;
    end else begin
      best_new  = best_q;
      label_new = label_q;
    end
  end

  assign thr_pass = $signed({best_new[DataW-1], best_new})
                    >= $signed({{(DataW+1-ThrW){1'b0}}, conf_thr_q});
  assign keep     = thr_pass && (kept_q < max_obj_q);
  assign kept_inc = kept_q + ObjW'(1);

  // box corners from center and half size
  assign cx_x = {box_q[0][DataW-1], box_q[0]};
  assign cy_x = {box_q[1][DataW-1], box_q[1]};
  assign hw_x = {{2{box_q[2][DataW-1]}}, box_q[2][DataW-1:1]};
  assign hh_x = {{2{box_q[3][DataW-1]}}, box_q[3][DataW-1:1]};

  always_comb begin
    coef_d   = coef_q;
    box_d    = box_q;
    pos_d    = pos_q;
    best_d   = best_q;
    label_d  = label_q;
    kept_d   = kept_q;
    anchor_d = anchor_q;
    full_d   = full_q;
    kpx_d    = kpx_q;
    kpy_d    = kpy_q;
    kpc_d    = kpc_q;
    emit     = 1'b0;

    req            = '0;
    req.coef       = coef_q;
    req.meta.label = label_new;

    if (in_xfer) begin
      if (in_cmd == CMD_LOAD) begin
        for (int i = 0; i < CoefCount; i++) begin
          if (in_idx == CoefIdxW'(i)) begin
            coef_d[i] = in_value;
          end
        end
        kept_d   = '0;
        full_d   = 1'b0;
        pos_d    = '0;
        anchor_d = 1'b0;
        kpc_d    = '0;
        best_d   = '0;
        label_d  = '0;
      end else if (!(full_q && !anchor_q)) begin
        if (pos_q >= row_len) begin
          // row shrank under us: take this value as the row end
          pos_d    = '0;
          anchor_d = 1'b0;
          kpc_d    = '0;
        end else begin
          if (pos_q < PosW'(BoxFields)) begin
            box_d[pos_q[1:0]] = in_value;
          end else if (pos_q < cls_end) begin
            best_d  = best_new;
            label_d = label_new;
            if (cls_last) begin
              if (keep) begin
                anchor_d = 1'b1;
                kept_d   = kept_inc;
                if (kept_inc >= max_obj_q) begin
                  full_d = 1'b1;
                end
                emit           = 1'b1;
                req.meta.kind  = KIND_BOX;
                req.meta.score = best_new;
                req.meta.last  = (nk_eff == '0);
                req.x0         = sat_s33(cx_x - hw_x);
                req.y0         = sat_s33(cy_x - hh_x);
                req.x1         = sat_s33(cx_x + hw_x);
                req.y1         = sat_s33(cy_x + hh_x);
              end else if (kept_q >= max_obj_q) begin
                full_d = 1'b1;
              end
            end
          end else begin
            unique case (kp_phase)
              KP_X: begin
                kpx_d = in_value;
              end
              KP_Y: begin
                kpy_d = in_value;
              end
              KP_CONF: begin
                if (anchor_q) begin
                  emit             = 1'b1;
                  req.meta.kind    = KIND_KPT;
                  req.meta.score   = in_value;
                  req.meta.label   = label_q;
                  req.meta.kpt_idx = kpc_q;
                  req.meta.last    = ((NkW'(kpc_q) + NkW'(1)) == nk_eff);
                  req.x0           = kpx_q;
                  req.y0           = kpy_q;
                end
                kpc_d = kpc_q + KptIdxW'(1);
              end
              default: begin
                kpx_d = kpx_q;
              end
            endcase
          end
          // advance, wrap at the row end
          if (pos_inc >= row_len) begin
            pos_d    = '0;
            anchor_d = 1'b0;
            kpc_d    = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_count_q <= NcW'(1);
      num_kpts_q  <= '0;
      conf_thr_q  <= '0;
      max_obj_q   <= ObjW'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_CLASS_COUNT:    cls_count_q <= cfg_wdata_i[NcW-1:0];
        REG_NUM_KEYPOINTS:  num_kpts_q  <= cfg_wdata_i[NkW-1:0];
        REG_CONF_THRESHOLD: conf_thr_q  <= cfg_wdata_i[ThrW-1:0];
        REG_MAX_OBJECTS:    max_obj_q   <= cfg_wdata_i[ObjW-1:0];
        default:            cls_count_q <= cls_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      box_q    <= '0;
      pos_q    <= '0;
      best_q   <= '0;
      label_q  <= '0;
      kept_q   <= '0;
      anchor_q <= 1'b0;
      full_q   <= 1'b0;
      kpx_q    <= '0;
      kpy_q    <= '0;
      kpc_q    <= '0;
    end else begin
      coef_q   <= coef_d;
      box_q    <= box_d;
      pos_q    <= pos_d;
      best_q   <= best_d;
      label_q  <= label_d;
      kept_q   <= kept_d;
      anchor_q <= anchor_d;
      full_q   <= full_d;
      kpx_q    <= kpx_d;
      kpy_q    <= kpy_d;
      kpc_q    <= kpc_d;
    end
  end

  ypbd_proj u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_xfer && emit),
    .in_ready_o  (proj_ready),
    .in_i        (req),
    .out_valid_o (res_valid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign s_axis_tready = proj_ready;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, res.keypoint_index, res.label, res.score,
                          res.box_height, res.box_width, res.coord_b, res.coord_a};
  assign m_axis_tuser  = res.kind;
  assign m_axis_tlast  = res.last;

endmodule

`default_nettype wire

// ===== src/ypbd_proj.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ypbd_proj (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ypbd_pkg::ypbd_req_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ypbd_pkg::ypbd_res_t out_o
);

  import ypbd_pkg::*;

  // stage valids
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic en1, en2, en3, en_out;

  // stage 1: operands and coefficient snapshot
  ypbd_req_t s1_q;

  // stage 2: floored products
  ypbd_meta_t          s2_meta_q;
  logic [ProdW-1:0]    prod_d [8];
  logic [ProdW-1:0]    prod_q [8];
  logic [DataW-1:0]    s2_m2_q, s2_m5_q;

  // stage 3: projected corners (or keypoint in l/t)
  ypbd_meta_t          s3_meta_q;
  logic [DataW-1:0]    l_d, t_d, r_d, b_d;
  logic [DataW-1:0]    l_q, t_q, r_q, b_q;

  ypbd_res_t           out_d, out_q;

  logic signed [2*DataW-1:0] mul [8];
  logic [DataW:0]            sum_x, sum_y, dif_x, dif_y;

  assign en_out     = !out_valid_q || out_ready_i;
  assign en3        = !s3_valid_q || en_out;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // eight multipliers: lanes 0..3 for the first point, 4..7 for the second
  assign mul[0] = $signed(s1_q.coef[0]) * $signed(s1_q.x0);
  assign mul[1] = $signed(s1_q.coef[1]) * $signed(s1_q.y0);
  assign mul[2] = $signed(s1_q.coef[3]) * $signed(s1_q.x0);
  assign mul[3] = $signed(s1_q.coef[4]) * $signed(s1_q.y0);
  assign mul[4] = $signed(s1_q.coef[0]) * $signed(s1_q.x1);
  assign mul[5] = $signed(s1_q.coef[1]) * $signed(s1_q.y1);
  assign mul[6] = $signed(s1_q.coef[3]) * $signed(s1_q.x1);
  assign mul[7] = $signed(s1_q.coef[4]) * $signed(s1_q.y1);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      prod_d[i] = mul[i][2*DataW-1:2*DataW-ProdW];
    end
  end

  function automatic logic [DataW-1:0] proj_sum(input logic [ProdW-1:0] pa,
                                                input logic [ProdW-1:0] pb,
                                                input logic [DataW-1:0] off);
    logic [SumW-1:0] s;
    s = {{(SumW-ProdW){pa[ProdW-1]}}, pa} + {{(SumW-ProdW){pb[ProdW-1]}}, pb}
      + {{(SumW-DataW){off[DataW-1]}}, off};
    return sat_sum(s);
  endfunction

  assign l_d = proj_sum(prod_q[0], prod_q[1], s2_m2_q);
  assign t_d = proj_sum(prod_q[2], prod_q[3], s2_m5_q);
  assign r_d = proj_sum(prod_q[4], prod_q[5], s2_m2_q);
  assign b_d = proj_sum(prod_q[6], prod_q[7], s2_m5_q);

  assign sum_x = {l_q[DataW-1], l_q} + {r_q[DataW-1], r_q};
  assign sum_y = {t_q[DataW-1], t_q} + {b_q[DataW-1], b_q};
  assign dif_x = {r_q[DataW-1], r_q} - {l_q[DataW-1], l_q};
  assign dif_y = {b_q[DataW-1], b_q} - {t_q[DataW-1], t_q};

  always_comb begin
    out_d.kind           = s3_meta_q.kind;
    out_d.score          = s3_meta_q.score;
    out_d.label          = s3_meta_q.label;
    out_d.keypoint_index = s3_meta_q.kpt_idx;
    out_d.last           = s3_meta_q.last;
    if (s3_meta_q.kind == KIND_BOX) begin
      out_d.coord_a    = sum_x[DataW:1];
      out_d.coord_b    = sum_y[DataW:1];
      out_d.box_width  = sat_s33(dif_x);
      out_d.box_height = sat_s33(dif_y);
    end else begin
      out_d.coord_a    = l_q;
      out_d.coord_b    = t_q;
      out_d.box_width  = '0;
      out_d.box_height = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (en_out) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q <= in_i;
    end
    if (en2 && s1_valid_q) begin
      s2_meta_q <= s1_q.meta;
      s2_m2_q   <= s1_q.coef[2];
      s2_m5_q   <= s1_q.coef[5];
      prod_q    <= prod_d;
    end
    if (en3 && s2_valid_q) begin
      s3_meta_q <= s2_meta_q;
      l_q       <= l_d;
      t_q       <= t_d;
      r_q       <= r_d;
      b_q       <= b_d;
    end
    if (en_out && s3_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== src/ypbd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ypbd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ypbd_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  import ypbd_pkg::*;

  // a stalled result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // the input side backs up only behind a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output could drain");

  // box results carry keypoint index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_BOX) |-> m_axis_tdata[172:168] == '0)
    else $error("box result with nonzero keypoint index");

  // keypoint results carry zero width and height
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_KPT) |-> m_axis_tdata[127:64] == '0)
    else $error("keypoint result with nonzero size");

endmodule

bind yolo_pose_box_decode ypbd_checker u_ypbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ypbd_pkg::*;

  localparam int unsigned TotalValues = 1750;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InTdataW-1:0]     s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutTdataW-1:0]    m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgAddrW-1:0]     cfg_addr_i = '0;
  logic [CfgDataW-1:0]     cfg_wdata_i = '0;

  yolo_pose_box_decode i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial forever #2 clk_i = ~clk_i;

  // decoder configuration as written
  logic [NcW-1:0]  cfg_classes = 1;
  logic [NkW-1:0]  cfg_kpts    = 0;
  logic [ThrW-1:0] cfg_thr     = 0;
  logic [ObjW-1:0] cfg_max_obj = 1024;

  // decoder frame state
  logic signed [DataW-1:0] coef_q [CoefCount] = '{default: '0};
  logic signed [DataW-1:0] box_q [BoxFields]  = '{default: '0};
  logic signed [DataW-1:0] kp_q [2]           = '{default: '0};
  logic signed [DataW-1:0] best_q   = '0;
  logic [ClassW-1:0]       best_cls = '0;
  logic [KptIdxW-1:0]      kp_num   = '0;
  int unsigned             row_pos  = 0;
  int unsigned             kept     = 0;
  bit                      kept_now = 1'b0;
  bit                      full     = 1'b0;

  ypbd_res_t   detections_due [$];
  int unsigned values_sent = 0;
  int unsigned bad_results = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  function automatic int unsigned row_classes();
    if (cfg_classes < 1) return 1;
    if (cfg_classes > MaxClasses) return MaxClasses;
    return cfg_classes;
  endfunction

  function automatic int unsigned row_keypoints();
    return (cfg_kpts > MaxKeypoints) ? MaxKeypoints : cfg_kpts;
  endfunction

  function automatic logic signed [DataW-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction

  function automatic void map_point(input logic signed [DataW-1:0] x, y,
                                    output logic signed [DataW-1:0] ox, oy);
    ox = clamp32(((longint'(coef_q[0]) * longint'(x)) >>> 16)
                 + ((longint'(coef_q[1]) * longint'(y)) >>> 16) + longint'(coef_q[2]));
    oy = clamp32(((longint'(coef_q[3]) * longint'(x)) >>> 16)
                 + ((longint'(coef_q[4]) * longint'(y)) >>> 16) + longint'(coef_q[5]));
  endfunction

  // Advance the decoder by one value; returns 1 when the value yields a detection.
  function automatic bit decode_value(input cmd_e cmd, input logic [CoefIdxW-1:0] idx,
                                      input logic signed [DataW-1:0] val,
                                      output ypbd_res_t det);
    int unsigned nc, nk, len, pos, c, k;
    logic signed [DataW-1:0] l, t, r, b;
    longint hw, hh;
    bit got;
    got = 1'b0;
    det = '0;
    if (cmd == CMD_LOAD) begin
      if (idx < CoefCount) coef_q[idx] = val;
      kept = 0;
      full = 1'b0;
      row_pos = 0;
      kept_now = 1'b0;
      kp_num = '0;
      best_q = '0;
      best_cls = '0;
      return 1'b0;
    end
    if (full && !kept_now) begin
      return 1'b0;
    end
    nc = row_classes();
    nk = row_keypoints();
    len = BoxFields + nc + 3 * nk;
    pos = row_pos;
    // a shortened row ends here without a result
    if (pos >= len) begin
      row_pos = 0;
      kept_now = 1'b0;
      kp_num = '0;
      return 1'b0;
    end
    if (pos < BoxFields) begin
      box_q[pos] = val;
    end else if (pos < BoxFields + nc) begin
      c = pos - BoxFields;
      if (c == 0 || val > best_q) begin
        best_q = val;
        best_cls = c[ClassW-1:0];
      end
      if (c == nc - 1) begin
        if (longint'(best_q) >= longint'(cfg_thr) && kept < cfg_max_obj) begin
          hw = longint'(box_q[2]) >>> 1;
          hh = longint'(box_q[3]) >>> 1;
          map_point(clamp32(longint'(box_q[0]) - hw), clamp32(longint'(box_q[1]) - hh), l, t);
          map_point(clamp32(longint'(box_q[0]) + hw), clamp32(longint'(box_q[1]) + hh), r, b);
          kept_now = 1'b1;
          kept++;
          if (kept >= cfg_max_obj) full = 1'b1;
          det.kind = KIND_BOX;
          det.coord_a = clamp32((longint'(l) + longint'(r)) >>> 1);
          det.coord_b = clamp32((longint'(t) + longint'(b)) >>> 1);
          det.box_width = clamp32(longint'(r) - longint'(l));
          det.box_height = clamp32(longint'(b) - longint'(t));
          det.score = best_q;
          det.label = best_cls;
          det.keypoint_index = '0;
          det.last = (nk == 0);
          got = 1'b1;
        end else if (kept >= cfg_max_obj) begin
          full = 1'b1;
        end
      end
    end else begin
      k = pos - BoxFields - nc;
      if (k % 3 != KP_CONF) begin
        kp_q[k % 3] = val;
      end else begin
        if (kept_now) begin
          map_point(kp_q[0], kp_q[1], l, t);
          det.kind = KIND_KPT;
          det.coord_a = l;
          det.coord_b = t;
          det.score = val;
          det.label = best_cls;
          det.keypoint_index = kp_num;
          det.last = (int'(kp_num) + 1 == nk);
          got = 1'b1;
        end
        kp_num = kp_num + 1'b1;
      end
    end
    pos++;
    if (pos >= len) begin
      pos = 0;
      kept_now = 1'b0;
      kp_num = '0;
    end
    row_pos = pos;
    return got;
  endfunction

  function automatic logic [DataW-1:0] pick_coord(input int unsigned span);
    if ($urandom_range(4) == 0) return $urandom();
    return $urandom_range(span << 16);
  endfunction

  function automatic logic [DataW-1:0] pick_score();
    case ($urandom_range(5))
      0: return $urandom();
      1: return cfg_thr;
      2: return cfg_thr - 1;
      default: return cfg_thr + $urandom_range(65536) - 32768;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_coef(input int unsigned idx);
    if ($urandom_range(3) == 0) return $urandom();
    case (idx)
      0, 4: return $urandom_range(16384, 131072);
      1, 3: return $urandom_range(8192) - 4096;
      default: return $urandom_range(200 << 16) - (100 << 16);
    endcase
  endfunction

  task automatic send_value(input cmd_e cmd, input logic [CoefIdxW-1:0] idx,
                            input logic [DataW-1:0] val);
    ypbd_res_t det;
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {{(InTdataW - DataW - CoefIdxW){1'b0}}, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (decode_value(cmd, idx, val, det)) detections_due.push_back(det);
    values_sent++;
  endtask

  task automatic send_row();
    send_value(CMD_PRED, $urandom_range(7), pick_coord(640));
    send_value(CMD_PRED, $urandom_range(7), pick_coord(640));
    send_value(CMD_PRED, $urandom_range(7), pick_coord(200));
    send_value(CMD_PRED, $urandom_range(7), pick_coord(200));
    repeat (row_classes()) send_value(CMD_PRED, $urandom_range(7), pick_score());
    repeat (row_keypoints()) begin
      send_value(CMD_PRED, $urandom_range(7), pick_coord(640));
      send_value(CMD_PRED, $urandom_range(7), pick_coord(640));
      send_value(CMD_PRED, $urandom_range(7), pick_score());
    end
  endtask

  // Hold the input until every pending detection is out and the pipeline is empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (detections_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_decoder(input int unsigned nc, nk, thr, maxo);
    logic [CfgDataW-1:0] vals [4];
    int i;
    vals[0] = nc;
    vals[1] = nk;
    vals[2] = thr;
    vals[3] = maxo;
    for (i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i <= cfg_reg_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (cfg_reg_e'(i))
        REG_CLASS_COUNT:    cfg_classes = vals[i][NcW-1:0];
        REG_NUM_KEYPOINTS:  cfg_kpts = vals[i][NkW-1:0];
        REG_CONF_THRESHOLD: cfg_thr = vals[i][ThrW-1:0];
        REG_MAX_OBJECTS:    cfg_max_obj = vals[i][ObjW-1:0];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [DataW-1:0] got, want);
    if (got !== want) begin
      bad_results++;
      if (bad_results <= 10) $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // Zero coefficients project everything to the origin.
  task automatic test_reset_defaults();
    send_value(CMD_PRED, 0, 32'h0064_0000);
    send_value(CMD_PRED, 7, 32'h0032_0000);
    send_value(CMD_PRED, 0, 32'h0014_0000);
    send_value(CMD_PRED, 0, 32'h000a_0000);
    send_value(CMD_PRED, 0, 32'h0000_0000);
  endtask

  // Identity matrix, out-of-range indexes, then a saturating box.
  task automatic test_coefficient_loads();
    send_value(CMD_LOAD, 0, 32'h0001_0000);
    send_value(CMD_LOAD, 1, 32'h0000_0000);
    send_value(CMD_LOAD, 2, 32'h0000_0000);
    send_value(CMD_LOAD, 3, 32'h0000_0000);
    send_value(CMD_LOAD, 4, 32'h0001_0000);
    send_value(CMD_LOAD, 5, 32'h0000_0000);
    send_value(CMD_LOAD, 6, 32'hffff_ffff);
    send_value(CMD_LOAD, 7, 32'h8000_0000);
    send_value(CMD_PRED, 0, 32'h7fff_ffff);
    send_value(CMD_PRED, 0, 32'h8000_0000);
    send_value(CMD_PRED, 0, 32'h7fff_ffff);
    send_value(CMD_PRED, 0, 32'h8000_0000);
    send_value(CMD_PRED, 0, 32'h7fff_ffff);
  endtask

  // Shorten the row while the decoder sits past the new row end.
  task automatic test_mid_row_config();
    settle();
    program_decoder(2, 0, 0, 1024);
    repeat (5) send_value(CMD_PRED, $urandom_range(7), pick_coord(100));
    settle();
    program_decoder(1, 0, 0, 1024);
    send_value(CMD_PRED, 0, 32'h0001_0000);
    send_row();
  endtask

  task automatic test_random_frames();
    int unsigned block, rows, kind_pick, nc, nk, thr, maxo;
    int i;
    block = 0;
    while (values_sent < TotalValues) begin
      settle();
      case (block % 5)
        1: begin gap_pct = 88; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 88; end
        3: begin gap_pct = 8; stall_pct = 8; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      case (block)
        0: begin nc = 256; nk = 2; thr = 0; maxo = 2047; end
        1: begin nc = 0; nk = 0; thr = 65536; maxo = 0; end
        2: begin nc = 511; nk = 63; thr = 131071; maxo = 1; end
        default: begin
          nc = $urandom_range(1, 8);
          nk = $urandom_range(0, 5);
          case ($urandom_range(9))
            0: thr = 0;
            1: thr = 65536;
            default: thr = $urandom_range(65536);
          endcase
          case ($urandom_range(9))
            0: maxo = 0;
            1: maxo = 1;
            2, 3, 4: maxo = $urandom_range(2, 4);
            default: maxo = 1024;
          endcase
        end
      endcase
      program_decoder(nc, nk, thr, maxo);
      for (i = 0; i < CoefCount; i++) send_value(CMD_LOAD, i, pick_coef(i));
      rows = (row_classes() + 3 * row_keypoints() > 36) ? 1 : $urandom_range(3, 14);
      repeat (rows) begin
        kind_pick = $urandom_range(99);
        if (kind_pick < 85) begin
          send_row();
        end else if (kind_pick < 93) begin
          send_value(CMD_LOAD, $urandom_range(7), pick_coef($urandom_range(5)));
        end else begin
          // break row alignment
          repeat ($urandom_range(1, 3)) send_value(CMD_PRED, $urandom_range(7), $urandom());
        end
      end
      block++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ypbd_res_t want;
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (detections_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result: tdata %h", m_axis_tdata);
      end else begin
        want = detections_due.pop_front();
        compare_field("kind", m_axis_tuser, want.kind);
        compare_field("coord_a", m_axis_tdata[0 +: DataW], want.coord_a);
        compare_field("coord_b", m_axis_tdata[DataW +: DataW], want.coord_b);
        compare_field("box_width", m_axis_tdata[2*DataW +: DataW], want.box_width);
        compare_field("box_height", m_axis_tdata[3*DataW +: DataW], want.box_height);
        compare_field("score", m_axis_tdata[4*DataW +: DataW], want.score);
        compare_field("label", m_axis_tdata[5*DataW +: ClassW], want.label);
        compare_field("keypoint_index", m_axis_tdata[5*DataW+ClassW +: KptIdxW],
                      want.keypoint_index);
        compare_field("last", m_axis_tlast, want.last);
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_coefficient_loads();
    test_mid_row_config();
    test_random_frames();
    settle();
    bad_results += detections_due.size();
    if (bad_results == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ypbd_pkg.sv
src/ypbd_proj.sv
src/yolo_pose_box_decode.sv
src/ypbd_checker.sv
bench/testbench.sv
